// ===== rtl/rrur_pkg.sv =====
// Shared types and constants for the round-robin ultrasonic ranger.
// No dependencies; imported by every rrur module and the top level.
`default_nettype none

package rrur_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ECHO_W    = 3;
  localparam int unsigned PERIOD_W  = 20;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned SENSOR_W  = 2;
  localparam int unsigned WIDTH_W   = TIMEOUT_W + 1;  // echo width up to timeout + 1
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = PERIOD_W;
  localparam int unsigned MAX_SENSORS = 8;

  // Sensors polled in turn; echo and sensor index fields are sized for this count
  localparam int unsigned NUM_SENSORS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_SCALE     = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic [PERIOD_W-1:0]  period;
    logic [TIMEOUT_W-1:0] timeout;
    logic [SCALE_W-1:0]   scale;
    logic [DIST_W-1:0]    threshold;
  } cfg_t;

  // Outcome of one tick from the sequencer
  typedef struct packed {
    logic               trig;
    logic               done;
    logic               valid;
    logic [WIDTH_W-1:0] width;
  } reading_t;

endpackage

`default_nettype wire

// ===== rtl/rrur_cfg.sv =====
// Configuration register file of the ultrasonic ranger.
// Depends on rrur_pkg for the register index codes and the cfg_t struct.
`default_nettype none

module rrur_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rrur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rrur_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output rrur_pkg::cfg_t                       cfg
);
  import rrur_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period    <= PERIOD_W'(60000);
      cfg_r.timeout   <= TIMEOUT_W'(30000);
      cfg_r.scale     <= SCALE_W'(11239);
      cfg_r.threshold <= DIST_W'(300);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PERIOD:    cfg_r.period    <= cfg_wdata;
        REG_TIMEOUT:   cfg_r.timeout   <= cfg_wdata[TIMEOUT_W-1:0];
        REG_SCALE:     cfg_r.scale     <= cfg_wdata[SCALE_W-1:0];
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrur_ctrl.sv =====
// Measurement sequencer: period wait, trigger pulse, echo rise wait and
// echo width count, plus the round-robin sensor pointer. Uses rrur_pkg.
`default_nettype none

module rrur_ctrl #(
  parameter int unsigned TRIG_HIGH_TICKS = 10,
  parameter int unsigned TRIG_LOW_TICKS  = 2,
  parameter int unsigned SIDX_W          = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          tick,
  input  wire logic [rrur_pkg::ECHO_W-1:0]   echo_levels,
  input  rrur_pkg::cfg_t                     cfg,
  output rrur_pkg::reading_t                 rd,
  output logic [SIDX_W-1:0]                  sensor
);
  import rrur_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [SIDX_W-1:0]   sidx_r, sidx_nxt;
  logic [PERIOD_W-1:0] cnt_inc;
  logic [MAX_SENSORS-1:0] echo_ext;
  logic                echo;
  logic                finish;

  assign cnt_inc  = cnt_r + PERIOD_W'(1);
  assign echo_ext = {{(MAX_SENSORS-ECHO_W){1'b0}}, echo_levels};
  assign echo     = echo_ext[3'(sidx_r)];
  assign sensor   = sidx_r;

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sidx_nxt  = sidx_r;
    finish    = 1'b0;
    rd        = '0;
    unique case (phase_r)
      PH_WAIT: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= cfg.period || cnt_inc == '0) begin
          phase_nxt = PH_TRIG_LOW;
          cnt_nxt   = '0;
        end
      end
      PH_TRIG_LOW: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= PERIOD_W'(TRIG_LOW_TICKS)) begin
          phase_nxt = PH_TRIG_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_TRIG_HIGH: begin
        rd.trig = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= PERIOD_W'(TRIG_HIGH_TICKS)) begin
          phase_nxt = PH_WAIT_RISE;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_nxt = PH_MEASURE;
          cnt_nxt   = '0;
        end else if (cnt_r > PERIOD_W'(cfg.timeout)) begin
          finish = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > PERIOD_W'(cfg.timeout)) finish = 1'b1;
        end else begin
          // count never passes timeout here, so it fits the width field
          rd.width = WIDTH_W'(cnt_r) + WIDTH_W'(1);
          rd.valid = 1'b1;
          finish   = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        cnt_nxt   = '0;
      end
    endcase

    // Close the reading and step to the next sensor
    if (finish) begin
      rd.done   = 1'b1;
      phase_nxt = PH_WAIT;
      cnt_nxt   = '0;
      sidx_nxt  = (sidx_r == SIDX_W'(NUM_SENSORS - 1)) ? '0 : sidx_r + SIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cnt_r   <= '0;
      sidx_r  <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sidx_r  <= sidx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrur_store.sv =====
// Distance scaling, per-sensor reading store and obstacle detection.
// Depends on rrur_pkg for cfg_t and reading_t.
`default_nettype none

module rrur_store #(
  parameter int unsigned SIDX_W      = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         tick,
  input  rrur_pkg::cfg_t                    cfg,
  input  rrur_pkg::reading_t                rd,
  input  wire logic [SIDX_W-1:0]            sensor,
  output logic [rrur_pkg::DIST_W-1:0]       dist_mm,
  output logic                              obstacle
);
  import rrur_pkg::*;

  localparam int unsigned PROD_W = WIDTH_W + SCALE_W;

  logic [DIST_W-1:0] dist_r    [NUM_SENSORS];
  logic              valid_r   [NUM_SENSORS];
  logic [DIST_W-1:0] dist_nxt  [NUM_SENSORS];
  logic              valid_nxt [NUM_SENSORS];
  logic [PROD_W-1:0] prod;

  // Width times Q0.16 scale; zero width when the reading timed out
  assign prod    = PROD_W'(rd.width) * PROD_W'(cfg.scale);
  assign dist_mm = prod[SCALE_W +: DIST_W];

  // Store update and obstacle check on the updated contents
  always_comb begin
    obstacle = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      dist_nxt[i]  = dist_r[i];
      valid_nxt[i] = valid_r[i];
      if (rd.done && sensor == SIDX_W'(i)) begin
        dist_nxt[i]  = dist_mm;
        valid_nxt[i] = rd.valid;
      end
      if (valid_nxt[i] && dist_nxt[i] <= cfg.threshold) obstacle = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        dist_r[i]  <= '0;
        valid_r[i] <= 1'b0;
      end
    end else if (tick) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        dist_r[i]  <= dist_nxt[i];
        valid_r[i] <= valid_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/round_robin_ultrasonic_ranger.sv =====
// Top level of the round-robin ultrasonic ranger: config registers,
// sequencer, reading store and the result register. Uses rrur_pkg.
`default_nettype none

// Each input transfer is one microsecond tick carrying the echo levels of all
// sensors; each tick gives exactly one result transfer from a result
// register. A tick is taken every clock cycle unless the input stalls: all
// per-tick work (sequencer step, one 17x16 distance multiply, store update and
// threshold compare) sits between the state registers and the result register.
// Input stalls only while a result is held by a stalled output. A measurement
// waits period_ticks ticks, drives trigger low for TRIG_LOW_TICKS and high for
// TRIG_HIGH_TICKS, waits for the current sensor's echo and counts its width;
// distance_mm = (width * half_speed_scale) >> 16, 0 with valid low on timeout.
// Config writes are always ready and are registered in the config block.
module round_robin_ultrasonic_ranger #(
  parameter int unsigned TRIG_HIGH_TICKS = 10,
  parameter int unsigned TRIG_LOW_TICKS  = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Tick input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rrur_pkg::ECHO_W-1:0]     in_echo_levels,
  // Result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_trigger_out,
  output logic                                 out_obstacle,
  output logic                                 out_reading_done,
  output logic [rrur_pkg::SENSOR_W-1:0]        out_reading_sensor,
  output logic [rrur_pkg::DIST_W-1:0]          out_reading_distance_mm,
  output logic                                 out_reading_valid,
  // Config writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rrur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rrur_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import rrur_pkg::*;

  localparam int unsigned SIDX_W = SENSOR_W;

  cfg_t              cfg;
  reading_t          rd;
  logic [SIDX_W-1:0] sensor;
  logic [DIST_W-1:0] dist_mm;
  logic              obstacle;
  logic              tick;

  logic                out_valid_r, out_valid_nxt;
  logic                trig_r, obst_r, done_r, rvalid_r;
  logic [SENSOR_W-1:0] sensor_r;
  logic [DIST_W-1:0]   dist_r;

  // Hold input while the result register cannot drain
  assign in_stall = out_valid_r && out_stall;
  assign tick     = in_valid && !in_stall;

  rrur_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rrur_ctrl #(
    .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
    .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
    .SIDX_W          (SIDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .echo_levels (in_echo_levels),
    .cfg         (cfg),
    .rd          (rd),
    .sensor      (sensor)
  );

  rrur_store #(
    .SIDX_W      (SIDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg      (cfg),
    .rd       (rd),
    .sensor   (sensor),
    .dist_mm  (dist_mm),
    .obstacle (obstacle)
  );

  // Result register
  assign out_valid_nxt = tick || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      trig_r   <= rd.trig;
      obst_r   <= obstacle;
      done_r   <= rd.done;
      rvalid_r <= rd.valid;
      sensor_r <= rd.done ? SENSOR_W'(sensor) : '0;
      dist_r   <= dist_mm;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_trigger_out         = trig_r;
  assign out_obstacle            = obst_r;
  assign out_reading_done        = done_r;
  assign out_reading_sensor      = sensor_r;
  assign out_reading_distance_mm = dist_r;
  assign out_reading_valid       = rvalid_r;

endmodule

`default_nettype wire
